// File: rtl/phcal_pkg.sv
// Shared types and constants for the pH two-point calibration block.
package phcal_pkg;

   // Request and response payloads
   typedef struct packed {
      logic        req_type;
      logic [15:0] voltage_in;
   } phcal_req_type;

   typedef struct packed {
      logic signed [15:0] ph_value;
      logic [2:0]         status;
   } phcal_rsp_type;

   // Request kinds
   localparam logic REQ_MEASURE   = 1'b0;
   localparam logic REQ_CALIBRATE = 1'b1;

   // Response status codes
   typedef enum logic [2:0] {
      STATUS_MEASURED  = 3'd0,
      STATUS_SATURATED = 3'd1,
      STATUS_NEUTRAL   = 3'd2,
      STATUS_ACID      = 3'd3,
      STATUS_REJECTED  = 3'd4
   } phcal_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL,
      ST_PREP,
      ST_MAG,
      ST_DIV,
      ST_DONE
   } phcal_state_type;

   // Calibration windows in whole mV
   localparam logic [12:0] NEUTRAL_LO_MV = 13'd1323;
   localparam logic [12:0] NEUTRAL_HI_MV = 13'd1677;
   localparam logic [12:0] ACID_LO_MV    = 13'd1855;
   localparam logic [12:0] ACID_HI_MV    = 13'd2209;

   // Reset calibration points in whole mV
   localparam logic [10:0] NEUTRAL_RESET_MV = 11'd1500;
   localparam logic [11:0] ACID_RESET_MV    = 12'd2032;

   // Divider length: magnitude of the scaled numerator fits in 24 bits
   localparam int unsigned DIV_BITS = 24;

   // Saturation limits on the quotient magnitude
   localparam logic [23:0] POS_LIMIT = 24'd32767;
   localparam logic [23:0] NEG_LIMIT = 24'd32768;
   localparam logic [15:0] PH_MAX    = 16'h7FFF;
   localparam logic [15:0] PH_MIN    = 16'h8000;

endpackage

// File: rtl/ph_two_point_calibration_core.sv
// Top level: two-point pH calibration with a bit-serial divider.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   req     | in        | req_valid/req_ready | phcal_req_type (req_type, voltage_in)
//   rsp     | out       | rsp_valid/rsp_ready | phcal_rsp_type (ph_value, status)
//
// Sequence: a measure request passes setup, numerator, 24 radix-2
//   restoring-divider steps and result before its response is loaded; a
//   calibrate request is answered straight from ST_CAL.
// One request is in flight at a time; req_ready is high only when idle.
// The response register frees the sequencer as soon as it is loaded, so a
//   new request is taken while the previous response still waits.
// Reset (synchronous, active high) restores the 1500 mV / 2032 mV points.
//
// Math: with d = acid - neutral (always > 0) and
//   m = 7168*d + 192*(16*neutral - voltage_in),
//   1024*pH = trunc(m / d); the divider runs on |m| and the sign is reapplied.

module ph_two_point_calibration_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  phcal_pkg::phcal_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output phcal_pkg::phcal_rsp_type rsp_data
);
   import phcal_pkg::*;

   // Control
   phcal_state_type state_ff, state_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Calibration points
   logic [10:0] neutral_ff, neutral_in;
   logic [11:0] acid_ff, acid_in;

   // Datapath
   logic [15:0]          vin_ff, vin_in;
   logic [9:0]           dist_ff, dist_in;     // acid - neutral
   logic signed [17:0]   ofs_ff, ofs_in;       // 16*neutral - vin
   logic                 neg_ff, neg_in;       // sign of numerator
   logic [DIV_BITS-1:0]  quo_ff, quo_in;       // dividend out, quotient in
   logic [9:0]           rem_ff, rem_in;
   phcal_rsp_type        rsp_ff, rsp_in;

   // Combinational helpers
   logic                 out_free;
   logic [16:0]          mv_sum;
   logic [12:0]          mv;
   logic [11:0]          dist_full;
   logic signed [25:0]   term_d;
   logic signed [25:0]   term_o;
   logic signed [25:0]   num;
   logic signed [25:0]   num_abs;
   logic [10:0]          part;
   logic [10:0]          diff;
   logic                 qbit;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign mv_sum    = {1'b0, vin_ff} + 17'd8;
   assign mv        = mv_sum[16:4];
   assign dist_full = acid_ff - {1'b0, neutral_ff};

   // 7168*d = d<<13 - d<<10 ; 192*o = o<<7 + o<<6
   assign term_d  = $signed({3'b000, dist_ff, 13'b0}) - $signed({6'b000000, dist_ff, 10'b0});
   assign term_o  = $signed({ofs_ff[17], ofs_ff, 7'b0})
                  + $signed({{2{ofs_ff[17]}}, ofs_ff, 6'b0});
   assign num     = term_d + term_o;
   assign num_abs = num[25] ? -num : num;

   // One restoring step
   assign part = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff = part - {1'b0, dist_ff};
   assign qbit = (part >= {1'b0, dist_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         neutral_ff   <= NEUTRAL_RESET_MV;
         acid_ff      <= ACID_RESET_MV;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         neutral_ff   <= neutral_in;
         acid_ff      <= acid_in;
      end
   end

   always_ff @(posedge clock) begin
      vin_ff  <= vin_in;
      dist_ff <= dist_in;
      ofs_ff  <= ofs_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      neutral_in   = neutral_ff;
      acid_in      = acid_ff;
      vin_in       = vin_ff;
      dist_in      = dist_ff;
      ofs_in       = ofs_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               vin_in   = req_data.voltage_in;
               state_in = (req_data.req_type == REQ_CALIBRATE) ? ST_CAL : ST_PREP;
            end
         end
         ST_CAL: begin
            // round to mV, check windows, store and answer in one go
            if (out_free) begin
               rsp_in.ph_value = '0;
               if (mv >= NEUTRAL_LO_MV && mv <= NEUTRAL_HI_MV) begin
                  neutral_in    = mv[10:0];
                  rsp_in.status = STATUS_NEUTRAL;
               end else if (mv >= ACID_LO_MV && mv <= ACID_HI_MV) begin
                  acid_in       = mv[11:0];
                  rsp_in.status = STATUS_ACID;
               end else begin
                  rsp_in.status = STATUS_REJECTED;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PREP: begin
            dist_in  = dist_full[9:0];
            ofs_in   = $signed({3'b000, neutral_ff, 4'b0000}) - $signed({2'b00, vin_ff});
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = num[25];
            quo_in   = num_abs[DIV_BITS-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? diff[9:0] : part[9:0];
            quo_in = {quo_ff[DIV_BITS-2:0], qbit};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (!neg_ff) begin
                  if (quo_ff > POS_LIMIT) begin
                     rsp_in.ph_value = PH_MAX;
                     rsp_in.status   = STATUS_SATURATED;
                  end else begin
                     rsp_in.ph_value = quo_ff[15:0];
                     rsp_in.status   = STATUS_MEASURED;
                  end
               end else begin
                  if (quo_ff > NEG_LIMIT) begin
                     rsp_in.ph_value = PH_MIN;
                     rsp_in.status   = STATUS_SATURATED;
                  end else begin
                     rsp_in.ph_value = 16'd0 - quo_ff[15:0];
                     rsp_in.status   = STATUS_MEASURED;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dist_ff))
      else $error("divider remainder out of range");

   // Calibration windows keep neutral below acid
   a_point_order: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, neutral_ff} < acid_ff))
      else $error("neutral point not below acid point");

   // A saturated response sits at one of the limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_SATURATED) |->
      (rsp_ff.ph_value == PH_MAX || rsp_ff.ph_value == PH_MIN))
      else $error("saturated response not at a limit");

   // Calibrate responses carry a zero pH value
   a_cal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_NEUTRAL || rsp_ff.status == STATUS_ACID
                        || rsp_ff.status == STATUS_REJECTED)) |->
      (rsp_ff.ph_value == '0))
      else $error("calibrate response with nonzero pH");

endmodule
